@@ sv/i2da_pkg.sv @@
package i2da_pkg;

   localparam int VALUE_WIDTH = 64;
   localparam int IN_W        = 64;
   localparam int DIGITS      = 20;
   localparam int BCD_W       = 4 * DIGITS;
   localparam int CHAR_W      = 6;
   localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);
   localparam int LEFT_W      = $clog2(DIGITS + 1);

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = CHAR_W'(48);
   localparam logic [CHAR_W-1:0] CHAR_MINUS = CHAR_W'(45);
   localparam logic [3:0]        RADIX_MAX  = 4'd9;

   typedef struct packed {
      logic             valid;
      logic             neg;
      logic [BCD_W-1:0] bcd;
   } bcd_type;

endpackage

@@ sv/i2da_if.sv @@
interface i2da_req_if;
   logic                      valid;
   logic                      ready;
   logic [i2da_pkg::IN_W-1:0] value;
   logic                      is_signed;

   modport source (output valid, output value, output is_signed, input ready);
   modport sink   (input valid, input value, input is_signed, output ready);
endinterface

interface i2da_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [i2da_pkg::CHAR_W-1:0] char_code;
   logic                        is_last;

   modport source (output valid, output char_code, output is_last, input ready);
   modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

@@ sv/integer_to_decimal_ascii.sv @@
// Converts a VALUE_WIDTH-bit integer (signed or unsigned per beat) into its
// decimal ASCII text, most significant character first, one character per
// rsp beat, with is_last on the final one; a negative signed value starts
// with '-'. The bit-serial converter runs shift-and-add-3 over all
// VALUE_WIDTH (64) input bits and then hands its digits to the emitter.
// The emitter skips leading zeros one at a time, never the last digit,
// emits the sign if any, and then the digits; skipped zeros and digits
// always add up to 20. The converter takes the next req beat in the cycle
// after the handoff, so the shifting of one value overlaps the output of
// the previous one. While rsp keeps up, the pace at which items are
// accepted is set by the shift loop, as the converter takes no new req
// beat while shifting. rsp stalls that keep the emitter busy past the
// next handoff hold the converter full, and req ready stays low until the
// emitter takes the digits.
module integer_to_decimal_ascii (
   input  logic       clock,
   input  logic       reset,
   i2da_req_if.sink   req_ch,
   i2da_rsp_if.source rsp_ch
);

   i2da_pkg::bcd_type conv;
   logic              conv_take;

   i2da_dabble u_dabble (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .conv      (conv),
      .conv_take (conv_take)
   );

   i2da_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .conv      (conv),
      .conv_take (conv_take),
      .rsp_ch    (rsp_ch)
   );

endmodule

@@ sv/i2da_dabble.sv @@
module i2da_dabble (
   input  logic                clock,
   input  logic                reset,
   i2da_req_if.sink            req_ch,
   output i2da_pkg::bcd_type   conv,
   input  logic                conv_take
);

   logic                                busy_ff, busy_in;
   logic                                full_ff, full_in;
   logic                                neg_ff, neg_in;
   logic [i2da_pkg::CNT_W-1:0]          cnt_ff, cnt_in;
   logic [i2da_pkg::VALUE_WIDTH-1:0]    bin_ff, bin_in;
   logic [i2da_pkg::BCD_W-1:0]          bcd_ff, bcd_in;
   logic [i2da_pkg::BCD_W-1:0]          bcd_adj;
   logic [i2da_pkg::VALUE_WIDTH-1:0]    v;
   logic                                neg;

   always_comb begin
      for (int d = 0; d < i2da_pkg::DIGITS; d++) begin
         if (bcd_ff[4*d +: 4] > 4'd4) begin
            bcd_adj[4*d +: 4] = bcd_ff[4*d +: 4] + 4'd3;
         end else begin
            bcd_adj[4*d +: 4] = bcd_ff[4*d +: 4];
         end
      end
   end

   always_comb begin
      req_ch.ready = !busy_ff && !full_ff;
      v   = req_ch.value[i2da_pkg::VALUE_WIDTH-1:0];
      neg = req_ch.is_signed && v[i2da_pkg::VALUE_WIDTH-1];

      busy_in = busy_ff;
      full_in = full_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;

      if (req_ch.valid && req_ch.ready) begin
         busy_in = 1'b1;
         neg_in  = neg;
         bin_in  = neg ? (~v + 1'b1) : v;
         bcd_in  = '0;
         cnt_in  = i2da_pkg::CNT_W'(i2da_pkg::VALUE_WIDTH);
      end else if (busy_ff) begin
         bcd_in = {bcd_adj[i2da_pkg::BCD_W-2:0], bin_ff[i2da_pkg::VALUE_WIDTH-1]};
         bin_in = {bin_ff[i2da_pkg::VALUE_WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == i2da_pkg::CNT_W'(1)) begin
            busy_in = 1'b0;
            full_in = 1'b1;
         end
      end else if (full_ff && conv_take) begin
         full_in = 1'b0;
      end
   end

   assign conv.valid = full_ff;
   assign conv.neg   = neg_ff;
   assign conv.bcd   = bcd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         full_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         full_ff <= full_in;
      end
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   a_busy_cnt: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff != '0)
      else $error("shift counter empty while converting");

   a_busy_full: assert property (@(posedge clock) disable iff (reset)
      !(busy_ff && full_ff))
      else $error("converter busy while holding a result");

   a_done: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && cnt_ff == i2da_pkg::CNT_W'(1)) |=> full_ff)
      else $error("last shift did not post a result");

endmodule

@@ sv/i2da_emit.sv @@
module i2da_emit (
   input  logic                clock,
   input  logic                reset,
   input  i2da_pkg::bcd_type   conv,
   output logic                conv_take,
   i2da_rsp_if.source          rsp_ch
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SKIP,
      ST_SIGN,
      ST_DIGIT
   } state_type;

   state_type                           state_ff, state_in;
   logic [i2da_pkg::BCD_W-1:0]          bcd_ff, bcd_in;
   logic [i2da_pkg::LEFT_W-1:0]         left_ff, left_in;
   logic                                neg_ff, neg_in;
   logic                                valid_ff, valid_in;
   logic [i2da_pkg::CHAR_W-1:0]         char_ff, char_in;
   logic                                last_ff, last_in;
   logic                                out_free;
   logic [3:0]                          top;

   always_comb begin
      top       = bcd_ff[i2da_pkg::BCD_W-1 -: 4];
      out_free  = !valid_ff || rsp_ch.ready;
      conv_take = (state_ff == ST_IDLE);

      state_in = state_ff;
      bcd_in   = bcd_ff;
      left_in  = left_ff;
      neg_in   = neg_ff;
      valid_in = valid_ff && !rsp_ch.ready;
      char_in  = char_ff;
      last_in  = last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (conv.valid) begin
               bcd_in   = conv.bcd;
               neg_in   = conv.neg;
               left_in  = i2da_pkg::LEFT_W'(i2da_pkg::DIGITS);
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if (top == 4'd0 && left_ff != i2da_pkg::LEFT_W'(1)) begin
               bcd_in  = {bcd_ff[i2da_pkg::BCD_W-5:0], 4'd0};
               left_in = left_ff - 1'b1;
            end else begin
               state_in = neg_ff ? ST_SIGN : ST_DIGIT;
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               valid_in = 1'b1;
               char_in  = i2da_pkg::CHAR_MINUS;
               last_in  = 1'b0;
               state_in = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            if (out_free) begin
               valid_in = 1'b1;
               char_in  = i2da_pkg::CHAR_ZERO + {2'b00, top};
               last_in  = (left_ff == i2da_pkg::LEFT_W'(1));
               bcd_in   = {bcd_ff[i2da_pkg::BCD_W-5:0], 4'd0};
               left_in  = left_ff - 1'b1;
               if (left_ff == i2da_pkg::LEFT_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_ch.valid     = valid_ff;
   assign rsp_ch.char_code = char_ff;
   assign rsp_ch.is_last   = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      bcd_ff  <= bcd_in;
      left_ff <= left_in;
      neg_ff  <= neg_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   a_char_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (char_ff == i2da_pkg::CHAR_MINUS ||
                    (char_ff >= i2da_pkg::CHAR_ZERO &&
                     char_ff <= i2da_pkg::CHAR_ZERO + {2'b00, i2da_pkg::RADIX_MAX})))
      else $error("character out of range");

   a_left: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SKIP || state_ff == ST_DIGIT) |-> left_ff != '0)
      else $error("digit count exhausted while emitting");

   a_sign_not_last: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && char_ff == i2da_pkg::CHAR_MINUS) |-> !last_ff)
      else $error("minus sign marked as last character");

endmodule

@@ tb/tb_integer_to_decimal_ascii.sv @@
`timescale 1ns / 1ps

module tb_integer_to_decimal_ascii;

   localparam int RANDOM_ITEMS = 350;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int DRAIN_CYCLES = 150;
   localparam int MAX_REPORTS  = 100;

   typedef struct packed {
      logic [i2da_pkg::IN_W-1:0] value;
      logic                      is_signed;
   } number_type;

   typedef struct packed {
      logic [i2da_pkg::CHAR_W-1:0] char_code;
      logic                        is_last;
   } char_type;

   logic clock;
   logic reset;

   i2da_req_if req_ch ();
   i2da_rsp_if rsp_ch ();

   integer_to_decimal_ascii DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   number_type pending_numbers[$];
   char_type   expected_chars[$];
   number_type next_number;
   char_type   actual_char;
   char_type   wanted_char;
   int         send_idle_pct;
   int         stall_pct;
   int         total_numbers;
   int         accepted_count = 0;
   int         error_count = 0;
   int         cycle_count = 0;

   function automatic void predict_text(input logic [i2da_pkg::IN_W-1:0] value,
                                        input logic is_signed);
      logic [i2da_pkg::IN_W-1:0] mask;
      logic [i2da_pkg::IN_W-1:0] v;
      logic [i2da_pkg::IN_W-1:0] mag;
      logic                      neg;
      logic [3:0]                digits [i2da_pkg::DIGITS];
      int                        nd;
      char_type                  c;
      mask = {i2da_pkg::IN_W{1'b1}} >> (i2da_pkg::IN_W - i2da_pkg::VALUE_WIDTH);
      v    = value & mask;
      neg  = is_signed && v[i2da_pkg::VALUE_WIDTH-1];
      mag  = neg ? ((~v + 1'b1) & mask) : v;
      nd   = 0;
      do begin
         digits[nd] = 4'(mag % 64'd10);
         mag        = mag / 64'd10;
         nd++;
      end while (mag != 0 && nd < i2da_pkg::DIGITS);
      if (neg) begin
         c.char_code = i2da_pkg::CHAR_MINUS;
         c.is_last   = 1'b0;
         expected_chars.push_back(c);
      end
      for (int i = nd - 1; i >= 0; i--) begin
         c.char_code = i2da_pkg::CHAR_ZERO + i2da_pkg::CHAR_W'(digits[i]);
         c.is_last   = (i == 0);
         expected_chars.push_back(c);
      end
   endfunction

   function automatic void add_number(input logic [i2da_pkg::IN_W-1:0] value,
                                      input logic is_signed);
      number_type n;
      n.value     = value;
      n.is_signed = is_signed;
      pending_numbers.push_back(n);
   endfunction

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // drive the request channel
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid     <= 1'b0;
         req_ch.value     <= '0;
         req_ch.is_signed <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            predict_text(req_ch.value, req_ch.is_signed);
            accepted_count <= accepted_count + 1;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_numbers.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               next_number = pending_numbers.pop_front();
               req_ch.valid     <= 1'b1;
               req_ch.value     <= next_number.value;
               req_ch.is_signed <= next_number.is_signed;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // check each character beat against the oldest expectation
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            actual_char.char_code = rsp_ch.char_code;
            actual_char.is_last   = rsp_ch.is_last;
            if (expected_chars.size() == 0) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("%0t: unexpected beat, expected none, actual char %0d last %0b",
                           $time, actual_char.char_code, actual_char.is_last);
            end else begin
               wanted_char = expected_chars.pop_front();
               if (actual_char !== wanted_char) begin
                  error_count++;
                  if (error_count <= MAX_REPORTS)
                     $display("%0t: mismatch, expected char %0d last %0b, actual char %0d last %0b",
                              $time, wanted_char.char_code, wanted_char.is_last,
                              actual_char.char_code, actual_char.is_last);
               end
            end
         end
         rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      logic [i2da_pkg::IN_W-1:0] raw;
      logic [i2da_pkg::IN_W-1:0] small_mag;
      logic [i2da_pkg::IN_W-1:0] pow10;
      send_idle_pct  = 0;
      stall_pct      = 0;
      reset          = 1'b1;

      add_number(64'd0, 1'b0);
      add_number(64'd0, 1'b1);
      add_number(64'd1, 1'b0);
      add_number(64'd9, 1'b1);
      add_number(64'd10, 1'b0);
      add_number(64'd99, 1'b0);
      add_number(64'd100, 1'b1);
      add_number({64{1'b1}}, 1'b0);
      add_number({64{1'b1}}, 1'b1);
      add_number(64'h8000_0000_0000_0000, 1'b1);
      add_number(64'h8000_0000_0000_0000, 1'b0);
      add_number(64'h7FFF_FFFF_FFFF_FFFF, 1'b1);
      add_number(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
      add_number(64'd10000000000000000000, 1'b0);
      add_number(64'd9999999999999999999, 1'b0);
      add_number(-64'sd10, 1'b1);
      add_number(-64'sd10, 1'b0);
      add_number(64'd1234567890123456789, 1'b1);
      add_number(64'h8000_0000_0000_0001, 1'b1);
      add_number(64'h5555_5555_5555_5555, 1'b0);
      add_number(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         raw       = {$urandom, $urandom};
         small_mag = raw >> $urandom_range(63);
         pow10     = 64'd1;
         for (int k = $urandom_range(19); k > 0; k--)
            pow10 = pow10 * 64'd10;
         case ($urandom_range(4))
            0: add_number(raw, 1'($urandom_range(1)));
            1: add_number(small_mag, 1'($urandom_range(1)));
            2: add_number(~small_mag + 1'b1, 1'b1);
            3: add_number(pow10 + i2da_pkg::IN_W'($urandom_range(2)) - 64'd1,
                          1'($urandom_range(1)));
            default: add_number(i2da_pkg::IN_W'($urandom_range(1000)),
                                1'($urandom_range(1)));
         endcase
      end
      total_numbers = pending_numbers.size();

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (accepted_count < total_numbers / 4) @(posedge clock);
      send_idle_pct = 74;
      while (accepted_count < total_numbers / 2) @(posedge clock);
      send_idle_pct = 0;
      stall_pct     = 74;
      while (accepted_count < (3 * total_numbers) / 4) @(posedge clock);
      send_idle_pct = 8;
      stall_pct     = 8;

      while (accepted_count < total_numbers) @(posedge clock);
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (expected_chars.size() != 0)
         $display("%0t: missing beats, expected %0d more, actual 0",
                  $time, expected_chars.size());
      if (error_count == 0 && expected_chars.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
